// ===== rtl/core/scoo_pkg.sv =====
// Shared types, codes and constants of the sparse coordinate-list add/subtract block.
`default_nettype none

package scoo_pkg;

    // Store depth default and the cap on results that one compute item may emit.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MAX_RESULTS     = 32;
    localparam int NCW             = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int OP_W      = 2;
    localparam int COORD_W   = 8;
    localparam int KEY_W     = 2 * COORD_W;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = VAL_W + 1;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W = 2 * COORD_W + VAL_W;
    localparam int OUT_RAW_W = 2 * COORD_W + SUM_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_ENTRY    = 3'd0,
        STS_ACCEPT   = 3'd1,
        STS_REJECT   = 3'd2,
        STS_MISMATCH = 3'd3,
        STS_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS   = 3'd0,
        CFG_A_COLS   = 3'd1,
        CFG_B_ROWS   = 3'd2,
        CFG_B_COLS   = 3'd3,
        CFG_SUBTRACT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FLUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mismatch;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dims_ok;
        logic out_free;
        logic merge_done;
        logic step_blocked;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/scoo_dp.sv =====
// Datapath: configuration registers, both coordinate stores, merge unit and output register.
`default_nettype none

module scoo_dp #(
    parameter int MAX_ENTRIES = scoo_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire scoo_pkg::t_cmd                  i_cmd,
    output scoo_pkg::t_sts                       o_sts,
    input  wire logic [scoo_pkg::OP_W-1:0]       i_op,
    input  wire logic [scoo_pkg::COORD_W-1:0]    i_row,
    input  wire logic [scoo_pkg::COORD_W-1:0]    i_col,
    input  wire logic [scoo_pkg::VAL_W-1:0]      i_value,
    input  wire logic                            i_cfg_valid,
    input  wire logic [scoo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [scoo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [scoo_pkg::COORD_W-1:0]         o_out_row,
    output logic [scoo_pkg::COORD_W-1:0]         o_out_col,
    output logic signed [scoo_pkg::SUM_W-1:0]    o_out_value,
    output logic [scoo_pkg::STATUS_W-1:0]        o_out_status,
    output logic                                 o_out_last
);
    import scoo_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Configuration.
    logic [COORD_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic               r_sub;

    // Stores, keys and values in separate arrays.
    logic [KEY_W-1:0] r_key_a [MAX_ENTRIES];
    logic [VAL_W-1:0] r_val_a [MAX_ENTRIES];
    logic [KEY_W-1:0] r_key_b [MAX_ENTRIES];
    logic [VAL_W-1:0] r_val_b [MAX_ENTRIES];
    logic [CW-1:0]    r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [KEY_W-1:0] r_last_a, r_last_b, n_last_a, n_last_b;

    // Merge walk and the result held back until its successor is known.
    logic [CW-1:0]            r_ia, r_ib, n_ia, n_ib;
    logic [NCW-1:0]           r_n, n_n;
    logic                     r_pend_valid, n_pend_valid;
    logic [KEY_W-1:0]         r_pend_key, n_pend_key;
    logic signed [SUM_W-1:0]  r_pend_value, n_pend_value;

    // Output register.
    logic                     r_out_valid, n_out_valid;
    logic [KEY_W-1:0]         r_out_key, n_out_key;
    logic signed [SUM_W-1:0]  r_out_value, n_out_value;
    logic [STATUS_W-1:0]      r_out_status, n_out_status;
    logic                     r_out_last, n_out_last;

    // Load check.
    logic               sel_b;
    logic [COORD_W-1:0] lim_rows, lim_cols;
    logic [CW-1:0]      cur_cnt;
    logic [KEY_W-1:0]   cur_last, in_key;
    logic               load_ok, wr_a, wr_b;

    // Merge step.
    logic                    a_avail, b_avail, take_a, take_b, sum_nz, out_free;
    logic [KEY_W-1:0]        ka, kb, step_key;
    logic signed [SUM_W-1:0] term_a, term_b, b_ext, step_sum;

    assign sel_b    = (i_op == OP_LOAD_B);
    assign lim_rows = sel_b ? r_b_rows : r_a_rows;
    assign lim_cols = sel_b ? r_b_cols : r_a_cols;
    assign cur_cnt  = sel_b ? r_cnt_b : r_cnt_a;
    assign cur_last = sel_b ? r_last_b : r_last_a;
    assign in_key   = {i_row, i_col};
    assign load_ok  = (i_row != '0) && (i_row <= lim_rows) && (i_col != '0) &&
                      (i_col <= lim_cols) && (cur_cnt != CW'(MAX_ENTRIES)) &&
                      (in_key > cur_last);
    assign wr_a     = i_cmd.load && load_ok && !sel_b;
    assign wr_b     = i_cmd.load && load_ok && sel_b;

    assign a_avail  = (r_ia != r_cnt_a);
    assign b_avail  = (r_ib != r_cnt_b);
    assign ka       = r_key_a[r_ia[IW-1:0]];
    assign kb       = r_key_b[r_ib[IW-1:0]];
    assign take_a   = a_avail && (!b_avail || ka <= kb);
    assign take_b   = b_avail && (!a_avail || kb <= ka);
    assign step_key = take_a ? ka : kb;
    assign b_ext    = SUM_W'(signed'(r_val_b[r_ib[IW-1:0]]));
    assign term_a   = take_a ? SUM_W'(signed'(r_val_a[r_ia[IW-1:0]])) : '0;
    assign term_b   = take_b ? (r_sub ? -b_ext : b_ext) : '0;
    assign step_sum = term_a + term_b;
    assign sum_nz   = (step_sum != '0);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.dims_ok      = (r_a_rows == r_b_rows) && (r_a_cols == r_b_cols);
    assign o_sts.out_free     = out_free;
    assign o_sts.merge_done   = (!a_avail && !b_avail) || (r_n == NCW'(MAX_RESULTS));
    assign o_sts.step_blocked = sum_nz && r_pend_valid && !out_free;

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_last_a     = r_last_a;
        n_last_b     = r_last_b;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_pend_key   = r_pend_key;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_key    = r_out_key;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        if (i_cmd.load) begin
            n_out_valid  = 1'b1;
            n_out_key    = '0;
            n_out_value  = '0;
            n_out_status = load_ok ? STS_ACCEPT : STS_REJECT;
            n_out_last   = 1'b1;
            if (wr_a) begin
                n_cnt_a  = r_cnt_a + 1'b1;
                n_last_a = in_key;
            end
            if (wr_b) begin
                n_cnt_b  = r_cnt_b + 1'b1;
                n_last_b = in_key;
            end
        end

        if (i_cmd.mismatch) begin
            n_out_valid  = 1'b1;
            n_out_key    = '0;
            n_out_value  = '0;
            n_out_status = STS_MISMATCH;
            n_out_last   = 1'b1;
        end

        if (i_cmd.start) begin
            n_ia         = '0;
            n_ib         = '0;
            n_n          = '0;
            n_pend_valid = 1'b0;
        end

        if (i_cmd.step) begin
            if (take_a) begin
                n_ia = r_ia + 1'b1;
            end
            if (take_b) begin
                n_ib = r_ib + 1'b1;
            end
            if (sum_nz) begin
                // The held result is not the last one, so it goes out now.
                if (r_pend_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_pend_key;
                    n_out_value  = r_pend_value;
                    n_out_status = STS_ENTRY;
                    n_out_last   = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_key   = step_key;
                n_pend_value = step_sum;
                n_n          = r_n + 1'b1;
            end
        end

        if (i_cmd.finish) begin
            n_out_valid  = 1'b1;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
            if (r_pend_valid) begin
                n_out_key    = r_pend_key;
                n_out_value  = r_pend_value;
                n_out_status = STS_ENTRY;
            end else begin
                n_out_key    = '0;
                n_out_value  = '0;
                n_out_status = STS_EMPTY;
            end
        end

        if (i_cmd.mismatch || i_cmd.finish) begin
            n_cnt_a  = '0;
            n_cnt_b  = '0;
            n_last_a = '0;
            n_last_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows     <= COORD_W'(1);
            r_a_cols     <= COORD_W'(1);
            r_b_rows     <= COORD_W'(1);
            r_b_cols     <= COORD_W'(1);
            r_sub        <= 1'b0;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_last_a     <= '0;
            r_last_b     <= '0;
            r_ia         <= '0;
            r_ib         <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_A_ROWS:   r_a_rows <= i_cfg_data;
                    CFG_A_COLS:   r_a_cols <= i_cfg_data;
                    CFG_B_ROWS:   r_b_rows <= i_cfg_data;
                    CFG_B_COLS:   r_b_cols <= i_cfg_data;
                    CFG_SUBTRACT: r_sub    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_last_a     <= n_last_a;
            r_last_b     <= n_last_b;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_n          <= n_n;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_key   <= n_pend_key;
        r_pend_value <= n_pend_value;
        r_out_key    <= n_out_key;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        if (wr_a) begin
            r_key_a[r_cnt_a[IW-1:0]] <= in_key;
            r_val_a[r_cnt_a[IW-1:0]] <= i_value;
        end
        if (wr_b) begin
            r_key_b[r_cnt_b[IW-1:0]] <= in_key;
            r_val_b[r_cnt_b[IW-1:0]] <= i_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_row    = r_out_key[KEY_W-1:COORD_W];
    assign o_out_col    = r_out_key[COORD_W-1:0];
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/scoo_ctrl.sv =====
// Controller state machine: accepts items and sequences the merge walk.
`default_nettype none

module scoo_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [scoo_pkg::OP_W-1:0] i_op,
    input  wire scoo_pkg::t_sts            i_sts,
    output scoo_pkg::t_cmd                 o_cmd
);
    import scoo_pkg::*;

    t_state r_state, n_state;
    logic   fire;

    assign fire = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (fire && i_op == OP_COMPUTE && i_sts.dims_ok) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (i_sts.merge_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (fire) begin
                    case (i_op)
                        OP_LOAD_A, OP_LOAD_B: o_cmd.load = 1'b1;
                        OP_COMPUTE: begin
                            o_cmd.start    = i_sts.dims_ok;
                            o_cmd.mismatch = !i_sts.dims_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                o_cmd.step = !i_sts.merge_done && !i_sts.step_blocked;
            end
            ST_FLUSH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sparse_coo_add_sub.sv =====
// A load answers in the output register in the cycle after its transfer.
// Throughput: loads one per cycle while the output keeps up; a compute item holds off input
// through the merge walk (at most count_a + count_b merged coordinates) and the flush, longer if the output stalls.
// The merge walk visits one coordinate of the two stores in each cycle unless a stalled output blocks its step.
// Reset (synchronous, active low) empties both stores and restores the dimension registers.
`default_nettype none

module sparse_coo_add_sub #(
    parameter int MAX_ENTRIES = scoo_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // row [7:0], col [15:8], value [31:16]
    input  wire logic [scoo_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation [1:0]
    input  wire logic [scoo_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // out_row [7:0], out_col [15:8], out_value [32:16], zeros above
    output logic [scoo_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    // status [2:0]
    output logic [scoo_pkg::STATUS_W-1:0]             m_axis_tuser,
    output logic                                      m_axis_tlast,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [scoo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [scoo_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import scoo_pkg::*;

    t_cmd                    cmd;
    t_sts                    sts;
    logic [COORD_W-1:0]      out_row, out_col;
    logic signed [SUM_W-1:0] out_value;

    scoo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scoo_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tuser),
        .i_row        (s_axis_tdata[COORD_W-1:0]),
        .i_col        (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_value      (s_axis_tdata[IN_DATA_W-1:2*COORD_W]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_row    (out_row),
        .o_out_col    (out_col),
        .o_out_value  (out_value),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, out_value, out_col, out_row};

`ifndef SYNTHESIS
    // An item is only taken when the output register can hold its answer.
    a_in_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input transfer while output register is stalled");

    // The controller issues at most one command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mismatch, cmd.start, cmd.step, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    // Every status result other than a merged entry ends its item.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != STS_ENTRY) |-> m_axis_tlast)
        else $error("status result without tlast");

    // A step never runs while the walk is already finished.
    a_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !sts.merge_done)
        else $error("merge step after the walk ended");
`endif

endmodule

`default_nettype wire

// ===== verif/sparse_coo_add_sub_checker.sv =====
// Checker for sparse_coo_add_sub: watches all channels, predicts every output transfer and compares.
module sparse_coo_add_sub_checker #(
    parameter int MAX_ENTRIES = scoo_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    input  wire logic                                 i_s_tready,
    input  wire logic [scoo_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  wire logic [scoo_pkg::OP_W-1:0]            i_s_tuser,
    input  wire logic                                 i_m_tvalid,
    input  wire logic                                 i_m_tready,
    input  wire logic [scoo_pkg::OUT_DATA_W-1:0]      i_m_tdata,
    input  wire logic [scoo_pkg::STATUS_W-1:0]        i_m_tuser,
    input  wire logic                                 i_m_tlast,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 i_cfg_ready,
    input  wire logic [scoo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [scoo_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int unsigned                               o_fail_count = 0,
    output int unsigned                               o_pending = 0,
    output int unsigned                               o_checked = 0
);
    timeunit 1ns;
    timeprecision 1ps;
    import scoo_pkg::*;

    localparam int STORE_A = 0;
    localparam int STORE_B = 1;

    typedef struct packed {
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      col;
        logic signed [SUM_W-1:0] value;
        t_status                 status;
        logic                    last;
    } t_result;

    t_result            pending_out[$];
    logic [KEY_W-1:0]   key_mem [2][MAX_ENTRIES];
    logic [VAL_W-1:0]   val_mem [2][MAX_ENTRIES];
    int unsigned        fill [2];
    logic [KEY_W-1:0]   high_key [2];
    logic [COORD_W-1:0] dim_rows [2];
    logic [COORD_W-1:0] dim_cols [2];
    logic               sub_mode;
    int unsigned        fails = 0;
    int unsigned        checked = 0;

    task automatic report(input string msg);
        $display("%0t checker: %s", $time, msg);
        fails++;
    endtask

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got) begin
            report($sformatf("%s: expected %0d, got %0d", name, want, got));
        end
    endtask

    task automatic queue_result(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                input logic signed [SUM_W-1:0] v, input t_status st,
                                input logic l);
        pending_out.push_back('{row: r, col: c, value: v, status: st, last: l});
    endtask

    task automatic empty_stores();
        fill[STORE_A] = 0;
        fill[STORE_B] = 0;
        high_key[STORE_A] = '0;
        high_key[STORE_B] = '0;
    endtask

    // Works out the output transfers that one input transfer causes.
    task automatic sparse_step(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
                               input logic [COORD_W-1:0] c, input logic [VAL_W-1:0] v);
        int unsigned             s;
        int unsigned             ia;
        int unsigned             ib;
        int unsigned             n;
        logic [KEY_W-1:0]        key;
        logic [KEY_W-1:0]        ka;
        logic [KEY_W-1:0]        kb;
        logic                    take_a;
        logic                    take_b;
        logic signed [SUM_W-1:0] sum;
        if (op == OP_LOAD_A || op == OP_LOAD_B) begin
            s = (op == OP_LOAD_B) ? STORE_B : STORE_A;
            key = {r, c};
            if (r == '0 || r > dim_rows[s] || c == '0 || c > dim_cols[s] ||
                    fill[s] >= MAX_ENTRIES || key <= high_key[s]) begin
                queue_result('0, '0, '0, STS_REJECT, 1'b1);
            end else begin
                key_mem[s][fill[s]] = key;
                val_mem[s][fill[s]] = v;
                fill[s]++;
                high_key[s] = key;
                queue_result('0, '0, '0, STS_ACCEPT, 1'b1);
            end
        end else if (op == OP_COMPUTE) begin
            if (dim_rows[STORE_A] != dim_rows[STORE_B] ||
                    dim_cols[STORE_A] != dim_cols[STORE_B]) begin
                queue_result('0, '0, '0, STS_MISMATCH, 1'b1);
            end else begin
                ia = 0;
                ib = 0;
                n = 0;
                // Row-major merge; equal keys combine into one sum.
                while ((ia < fill[STORE_A] || ib < fill[STORE_B]) && n < MAX_RESULTS) begin
                    ka = (ia < fill[STORE_A]) ? key_mem[STORE_A][ia] : '0;
                    kb = (ib < fill[STORE_B]) ? key_mem[STORE_B][ib] : '0;
                    take_a = ia < fill[STORE_A] && (ib >= fill[STORE_B] || ka <= kb);
                    take_b = ib < fill[STORE_B] && (ia >= fill[STORE_A] || kb <= ka);
                    key = take_a ? ka : kb;
                    sum = '0;
                    if (take_a) begin
                        sum += $signed(val_mem[STORE_A][ia]);
                        ia++;
                    end
                    if (take_b) begin
                        if (sub_mode) begin
                            sum -= $signed(val_mem[STORE_B][ib]);
                        end else begin
                            sum += $signed(val_mem[STORE_B][ib]);
                        end
                        ib++;
                    end
                    if (sum != '0) begin
                        queue_result(key[KEY_W-1:COORD_W], key[COORD_W-1:0], sum, STS_ENTRY,
                                     1'b0);
                        n++;
                    end
                end
                if (n == 0) begin
                    queue_result('0, '0, '0, STS_EMPTY, 1'b1);
                end else begin
                    pending_out[pending_out.size() - 1].last = 1'b1;
                end
            end
            empty_stores();
        end
        // The unused operation code causes nothing at all.
    endtask

    task automatic check_transfer();
        t_result want;
        if (pending_out.size() == 0) begin
            report($sformatf("output transfer with nothing pending: tdata %h, status %0d",
                             i_m_tdata, i_m_tuser));
        end else begin
            want = pending_out.pop_front();
            checked++;
            cmp_field("out_row", want.row, i_m_tdata[COORD_W-1:0]);
            cmp_field("out_col", want.col, i_m_tdata[KEY_W-1:COORD_W]);
            cmp_field("out_value", want.value, $signed(i_m_tdata[OUT_RAW_W-1:KEY_W]));
            cmp_field("tdata padding", 0, i_m_tdata[OUT_DATA_W-1:OUT_RAW_W]);
            cmp_field("status", want.status, i_m_tuser);
            cmp_field("tlast", want.last, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_out.delete();
            empty_stores();
            dim_rows[STORE_A] = 8'd1;
            dim_cols[STORE_A] = 8'd1;
            dim_rows[STORE_B] = 8'd1;
            dim_cols[STORE_B] = 8'd1;
            sub_mode = 1'b0;
        end else begin
            // A result leaving at this edge belongs to an earlier input, so check first.
            if (i_m_tvalid && i_m_tready) begin
                check_transfer();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_A_ROWS:   dim_rows[STORE_A] = i_cfg_data;
                    CFG_A_COLS:   dim_cols[STORE_A] = i_cfg_data;
                    CFG_B_ROWS:   dim_rows[STORE_B] = i_cfg_data;
                    CFG_B_COLS:   dim_cols[STORE_B] = i_cfg_data;
                    CFG_SUBTRACT: sub_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                sparse_step(i_s_tuser, i_s_tdata[COORD_W-1:0], i_s_tdata[KEY_W-1:COORD_W],
                            i_s_tdata[IN_DATA_W-1:KEY_W]);
            end
        end
        o_pending <= pending_out.size();
        o_fail_count <= fails;
        o_checked <= checked;
    end

endmodule

// ===== verif/tb_sparse_coo_add_sub.sv =====
// Testbench top for sparse_coo_add_sub: clock, reset, stimulus, watchdog and verdict.
module tb_sparse_coo_add_sub;
    timeunit 1ns;
    timeprecision 1ps;
    import scoo_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_PAD      = 8;
    localparam int RANDOM_ITEMS   = 100;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic [OP_W-1:0]          s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]      m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned n_items = 0;
    int unsigned n_settings = 0;
    int unsigned stall_cycles = 0;
    logic        idle_on = 1'b1;

    sparse_coo_add_sub #(
        .MAX_ENTRIES(MAX_ENTRIES_DEF)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    sparse_coo_add_sub_checker #(
        .MAX_ENTRIES(MAX_ENTRIES_DEF)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata),
        .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser),
        .i_m_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 34);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     WATCHDOG_LIMIT, pending);
            $display("tb_sparse_coo_add_sub failed");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Valid stays high between back-to-back transfers; it only drops for a gap.
    task automatic send(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
                        input logic [COORD_W-1:0] c, input logic [VAL_W-1:0] v);
        if (idle_on && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 34);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v, c, r};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_UNUSED) begin
            n_items++;
        end
    endtask

    // Waits until every predicted result has arrived, then lets the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic cfg_xfer(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_regs(input logic [7:0] ar, input logic [7:0] ac, input logic [7:0] br,
                              input logic [7:0] bc, input logic sub);
        cfg_xfer(CFG_A_ROWS, ar);
        cfg_xfer(CFG_A_COLS, ac);
        cfg_xfer(CFG_B_ROWS, br);
        cfg_xfer(CFG_B_COLS, bc);
        cfg_xfer(CFG_SUBTRACT, {7'd0, sub});
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int unsigned        frame;
        int unsigned        target;
        int unsigned        grid;
        int unsigned        step_max;
        int unsigned        pos;
        int unsigned        npos;
        int unsigned        k;
        int unsigned        which;
        logic [7:0]         ar;
        logic [7:0]         ac;
        logic [7:0]         br;
        logic [7:0]         bc;
        logic               sub;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [VAL_W-1:0]   va;
        logic [VAL_W-1:0]   vb;
        logic [OP_W-1:0]    nop;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset dimensions are 1x1 in add mode.
        send(OP_UNUSED, 8'hff, 8'hff, 16'hffff);
        send(OP_COMPUTE, 8'h00, 8'h00, 16'h0000);
        send(OP_LOAD_A, 8'd1, 8'd1, 16'h7fff);
        send(OP_LOAD_A, 8'd1, 8'd1, 16'h0001);
        send(OP_LOAD_A, 8'd0, 8'd0, 16'h0000);
        send(OP_LOAD_A, 8'd2, 8'd1, 16'h0100);
        send(OP_LOAD_A, 8'd1, 8'd2, 16'h0100);
        send(OP_LOAD_B, 8'd1, 8'd1, 16'h7fff);
        send(OP_LOAD_B, 8'd1, 8'd1, 16'h0002);
        send(OP_COMPUTE, 8'hff, 8'hff, 16'hffff);
        send(OP_LOAD_A, 8'd1, 8'd1, 16'h8000);
        send(OP_LOAD_B, 8'd1, 8'd1, 16'h8000);
        send(OP_COMPUTE, 8'h5a, 8'ha5, 16'h1234);
        drain();

        // Largest matrices, subtract mode; zero values and cancelling pairs drop out.
        write_regs(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send(OP_LOAD_A, 8'd1, 8'd1, 16'h0000);
        send(OP_LOAD_A, 8'd1, 8'd255, 16'h1234);
        send(OP_LOAD_A, 8'd255, 8'd255, 16'h8000);
        send(OP_LOAD_B, 8'd1, 8'd1, 16'h0000);
        send(OP_LOAD_B, 8'd1, 8'd255, 16'h1234);
        send(OP_LOAD_B, 8'd200, 8'd7, 16'h0005);
        send(OP_LOAD_B, 8'd255, 8'd255, 16'h7fff);
        send(OP_COMPUTE, 8'd0, 8'd0, 16'h0000);
        drain();

        // Column counts differ, so the compute reports a mismatch and clears the stores.
        write_regs(8'd3, 8'd4, 8'd3, 8'd5, 1'b0);
        send(OP_LOAD_A, 8'd1, 8'd1, 16'h0001);
        send(OP_LOAD_B, 8'd3, 8'd5, 16'h0002);
        send(OP_COMPUTE, 8'd0, 8'd0, 16'h0000);

        target = n_items + RANDOM_ITEMS;
        frame = 0;
        while (n_items < target) begin
            drain();
            // Frames three and four run with no gaps in input valid and with the output always ready.
            idle_on <= !(frame == 3 || frame == 4);
            ar = 8'($urandom_range(1, 255));
            ac = 8'($urandom_range(1, 255));
            case ($urandom_range(0, 5))
                0: begin
                    ar = 8'd255;
                    ac = 8'd255;
                end
                1: begin
                    ar = 8'd1;
                    ac = 8'd1;
                end
                2: begin
                    ar = 8'($urandom_range(1, 6));
                    ac = 8'($urandom_range(1, 6));
                end
                default: ;
            endcase
            br = ar;
            bc = ac;
            case ($urandom_range(0, 7))
                0: br = (ar == 8'd255) ? ar - 8'd1 : ar + 8'd1;
                1: bc = (ac == 8'd255) ? ac - 8'd1 : ac + 8'd1;
                default: ;
            endcase
            sub = 1'($urandom_range(0, 1));
            npos = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 12);
            // One frame is forced to overfill both stores.
            if (frame == 1) begin
                ar = 8'd8;
                ac = 8'd8;
                br = 8'd8;
                bc = 8'd8;
                npos = 30;
            end
            write_regs(ar, ac, br, bc, sub);

            grid = ar * ac;
            step_max = grid / (npos + 1);
            pos = $urandom_range(0, step_max);
            for (k = 0; k < npos && pos < grid; k++) begin
                r = COORD_W'(pos / ac + 1);
                c = COORD_W'(pos % ac + 1);
                va = rand_value();
                vb = ($urandom_range(0, 2) == 0) ? (sub ? va : -va) : rand_value();
                which = $urandom_range(0, 2);
                // Occasional stray transfer that breaks the ordered sequence.
                if ($urandom_range(0, 99) < 12) begin
                    case ($urandom_range(0, 3))
                        0: nop = OP_LOAD_A;
                        1: nop = OP_LOAD_B;
                        2: nop = OP_COMPUTE;
                        default: nop = OP_UNUSED;
                    endcase
                    send(nop, COORD_W'($urandom), COORD_W'($urandom), VAL_W'($urandom));
                end
                if (which != 1) begin
                    send(OP_LOAD_A, r, c, va);
                end
                if (which != 0) begin
                    send(OP_LOAD_B, r, c, vb);
                end
                pos += 1 + $urandom_range(0, step_max);
            end
            send(OP_COMPUTE, COORD_W'($urandom), COORD_W'($urandom), VAL_W'($urandom));
            frame++;
        end
        drain();

        $display("Run covered %0d input transfers over %0d register settings and %0d frames.",
                 n_items, n_settings, frame);
        $display("%0d output transfers were compared field by field.", checked);
        if (fail_count == 0) begin
            $display("tb_sparse_coo_add_sub passed");
        end else begin
            $display("tb_sparse_coo_add_sub failed");
        end
        $finish;
    end

endmodule

// ===== sparse_coo_add_sub.f =====
rtl/core/scoo_pkg.sv
rtl/core/scoo_dp.sv
rtl/core/scoo_ctrl.sv
rtl/core/sparse_coo_add_sub.sv
verif/sparse_coo_add_sub_checker.sv
verif/tb_sparse_coo_add_sub.sv
